// File: design/bwhp_pkg.sv
package bwhp_pkg;

	// Fixed geometry of a segment.
	localparam int WORD_BITS    = 64;
	localparam int MAX_ROWS_DEF = 32;

	// Field widths of the stream payloads.
	localparam int CODE_BITS      = 32;
	localparam int ROW_IDX_BITS   = 5;
	localparam int SEG_BITS       = 16;
	localparam int OUT_FIELD_BITS = WORD_BITS + ROW_IDX_BITS + SEG_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
	localparam int CODE_CNT_BITS  = 7;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 16;
	localparam int WSEL_BITS      = 2;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH_SELECT  = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SEGMENT_LIMIT = 8'd1;

	localparam logic [WSEL_BITS-1:0] WSEL_8  = 2'd0;
	localparam logic [WSEL_BITS-1:0] WSEL_16 = 2'd1;

	localparam logic [SEG_BITS-1:0] SEG_LIMIT_RESET = 16'hFFFF;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_FLUSH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic start_flush;
		logic flushing;
		logic emit;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic flush_needed;
		logic out_room;
		logic last_row;
	} status_t;

endpackage

// File: design/bitweaving_horizontal_packer_top.sv
// Horizontal bit-weaving packer.
// Input stream (s_*): one dictionary code per transaction in s_tdata; s_tlast
// marks the last code of a column. Configuration (cfg_*): index 0 selects the
// field width (8, 16 or 32 bits), index 1 sets the segment limit; cfg_ready is
// always high and writes belong in idle periods.
// Output stream (m_*): the row words of each finished segment, in row order,
// m_tlast on the final row of the segment.
// A code within the segment limit is merged into its row in the cycle it is
// accepted, so the block takes one code per cycle while no segment drains.
// A full segment, or a partial one closed by s_tlast, drains its W rows
// (W = field width) through the output register at one row per cycle, with
// s_tready low; a stall on m_tready holds the current word and pauses the
// drain. The first row word is loaded into the output register in the flush state.
// Reset clears the counters, the row valid bits and the configuration (width
// 8, limit 65535); the row store needs no clearing pass.
module bitweaving_horizontal_packer_top #(
	parameter int MAX_ROWS = bwhp_pkg::MAX_ROWS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bwhp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [bwhp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [31:0] code_value
	input  logic [bwhp_pkg::CODE_BITS-1:0]       s_tdata,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [63:0] packed_word, [68:64] row_index, [84:69] segment_index, rest zero
	output logic [bwhp_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
	output logic                                 m_tlast
);

	bwhp_pkg::cmd_t    cmd;
	bwhp_pkg::status_t status;

	bwhp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bwhp_datapath #(
		.MAX_ROWS (MAX_ROWS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.code_value    (s_tdata),
		.end_of_column (s_tlast),
		.cmd           (cmd),
		.status        (status),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast)
	);

endmodule

// File: design/bwhp_ctrl.sv
module bwhp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  bwhp_pkg::status_t status,
	output bwhp_pkg::cmd_t    cmd
);

	bwhp_pkg::state_t state_q;
	bwhp_pkg::state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bwhp_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands. Codes are taken only while no segment is draining.
	always_comb begin
		state_next      = state_q;
		s_tready        = 1'b0;
		cmd.accept      = 1'b0;
		cmd.start_flush = 1'b0;
		cmd.flushing    = 1'b0;
		cmd.emit        = 1'b0;
		cmd.finish      = 1'b0;
		unique case (state_q)
			bwhp_pkg::ST_IDLE: begin
				s_tready        = 1'b1;
				cmd.accept      = s_tvalid;
				cmd.start_flush = s_tvalid && status.flush_needed;
				if (cmd.start_flush) begin
					state_next = bwhp_pkg::ST_FLUSH;
				end
			end
			bwhp_pkg::ST_FLUSH: begin
				cmd.flushing = 1'b1;
				cmd.emit     = status.out_room;
				cmd.finish   = status.out_room && status.last_row;
				if (cmd.finish) begin
					state_next = bwhp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = bwhp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: design/bwhp_datapath.sv
module bwhp_datapath #(
	parameter int MAX_ROWS = bwhp_pkg::MAX_ROWS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bwhp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [bwhp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic [bwhp_pkg::CODE_BITS-1:0]       code_value,
	input  logic                                 end_of_column,
	input  bwhp_pkg::cmd_t                       cmd,
	output bwhp_pkg::status_t                    status,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bwhp_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
	output logic                                 m_tlast
);

	localparam int ROW_BITS = $clog2(MAX_ROWS);
	// Largest field width, as log2, that still fits the row store.
	localparam logic [2:0] MAX_LOG = (MAX_ROWS >= 32) ? 3'd5 : ((MAX_ROWS >= 16) ? 3'd4 : 3'd3);
	localparam int WB = bwhp_pkg::WORD_BITS;

	logic [bwhp_pkg::WSEL_BITS-1:0]     wsel_q;
	logic [bwhp_pkg::SEG_BITS-1:0]      limit_q;
	logic [bwhp_pkg::CODE_CNT_BITS-1:0] cnt_q;
	logic [bwhp_pkg::SEG_BITS-1:0]      seg_cnt_q;
	logic [bwhp_pkg::SEG_BITS-1:0]      flush_seg_q;
	logic [ROW_BITS-1:0]                rc_q;
	logic [WB-1:0]                      row_q [MAX_ROWS];
	logic [MAX_ROWS-1:0]                valid_q;

	logic [WB-1:0]                      out_word_q;
	logic [bwhp_pkg::ROW_IDX_BITS-1:0]  out_row_q;
	logic [bwhp_pkg::SEG_BITS-1:0]      out_seg_q;
	logic                               out_last_q;
	logic                               out_valid_q;

	logic [2:0]                         w_log;
	logic [ROW_BITS-1:0]                row_mask;
	logic [5:0]                         k;
	logic [ROW_BITS-1:0]                row_wr;
	logic [5:0]                         slot_shift;
	logic [WB-1:0]                      aligned;
	logic [WB-1:0]                      placed_word;
	logic [ROW_BITS-1:0]                rd_addr;
	logic [WB-1:0]                      rd_word;
	logic                               placed;
	logic [bwhp_pkg::CODE_CNT_BITS-1:0] cnt_next;
	logic                               full;
	logic                               clear_now;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsel_q  <= bwhp_pkg::WSEL_8;
			limit_q <= bwhp_pkg::SEG_LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bwhp_pkg::CFG_WIDTH_SELECT:  wsel_q  <= cfg_data[bwhp_pkg::WSEL_BITS-1:0];
				bwhp_pkg::CFG_SEGMENT_LIMIT: limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Field width as log2, capped at MAX_LOG; both unused select codes act as 32 bits.
	always_comb begin
		unique case (wsel_q)
			bwhp_pkg::WSEL_8:  w_log = 3'd3;
			bwhp_pkg::WSEL_16: w_log = 3'd4;
			default:           w_log = 3'd5;
		endcase
		if (w_log > MAX_LOG) begin
			w_log = MAX_LOG;
		end
	end

	assign row_mask = ROW_BITS'((6'd1 << w_log) - 6'd1);

	// Placement: row is k mod W, the offset from the top is k rounded down to W.
	assign k          = cnt_q[5:0];
	assign row_wr     = k[ROW_BITS-1:0] & row_mask;
	assign slot_shift = k & ~(6'(row_mask));

	always_comb begin
		case (w_log)
			3'd3:    aligned = {code_value[7:0], 56'd0};
			3'd4:    aligned = {code_value[15:0], 48'd0};
			default: aligned = {code_value, 32'd0};
		endcase
	end

	assign placed_word = aligned >> slot_shift;

	// Single read port, shared by the merge on accept and the drain.
	assign rd_addr = cmd.flushing ? rc_q : row_wr;
	assign rd_word = valid_q[rd_addr] ? row_q[rd_addr] : '0;

	assign placed   = seg_cnt_q < limit_q;
	assign cnt_next = cnt_q + 1'b1;
	assign full     = placed && (cnt_next == bwhp_pkg::CODE_CNT_BITS'(WB));

	assign status.flush_needed = full || (end_of_column && (placed || (cnt_q != '0)));
	assign status.out_room     = !out_valid_q || m_tready;
	assign status.last_row     = (rc_q == row_mask);

	// Row store; entries without a valid bit read as zero.
	always_ff @(posedge clk) begin
		if (cmd.accept && placed) begin
			row_q[row_wr] <= rd_word | placed_word;
		end
	end

	assign clear_now = (cmd.accept && end_of_column && !status.flush_needed) || cmd.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear_now) begin
			valid_q <= '0;
		end else if (cmd.accept && placed) begin
			valid_q[row_wr] <= 1'b1;
		end
	end

	// Code and segment counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			seg_cnt_q <= '0;
		end else if (cmd.accept) begin
			if (end_of_column) begin
				cnt_q     <= '0;
				seg_cnt_q <= '0;
			end else if (full) begin
				cnt_q     <= '0;
				seg_cnt_q <= seg_cnt_q + 1'b1;
			end else if (placed) begin
				cnt_q <= cnt_next;
			end
		end
	end

	// Drain bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q        <= '0;
			flush_seg_q <= '0;
		end else if (cmd.start_flush) begin
			rc_q        <= '0;
			flush_seg_q <= seg_cnt_q;
		end else if (cmd.emit) begin
			rc_q <= rc_q + 1'b1;
		end
	end

	// Output register; it holds a word while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_word_q <= rd_word;
			out_row_q  <= bwhp_pkg::ROW_IDX_BITS'(rc_q);
			out_seg_q  <= flush_seg_q;
			out_last_q <= status.last_row;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(bwhp_pkg::OUT_TDATA_BITS - bwhp_pkg::OUT_FIELD_BITS){1'b0}},
		out_seg_q, out_row_q, out_word_q};

endmodule

// File: design/bwhp_checker.sv
module bwhp_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [bwhp_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	input logic                                m_tlast
);

	// A stalled word stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed under stall");

	// No code is taken while a segment is partway through its drain.
	a_no_accept_mid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !(m_tvalid && !m_tlast))
		else $error("code accepted during segment drain");

	// The final row of a segment sits at W-1.
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[68:64] == 5'd7) || (m_tdata[68:64] == 5'd15)
			|| (m_tdata[68:64] == 5'd31))
		else $error("segment ends on an unexpected row");

	// Rows of a segment follow each other without gaps.
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid
			&& (m_tdata[68:64] == 5'($past(m_tdata[68:64]) + 5'd1)))
		else $error("row sequence broken");

endmodule

bind bitweaving_horizontal_packer_top bwhp_checker u_bwhp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
